[hw/rtl/pmst_pkg.sv]
// ----------------------------------------------------------------------------
// Package for the Prim minimum spanning tree core
// Shared result status codes, register indexes, sizes and the run status.
// ----------------------------------------------------------------------------
package pmst_pkg;

	localparam logic [1:0] STATUS_EDGE         = 2'd0;
	localparam logic [1:0] STATUS_DISCONNECTED = 2'd1;
	localparam logic [1:0] STATUS_SINGLE       = 2'd2;

	// Register indexes of the configuration port.
	localparam logic CFG_VERTEX_COUNT = 1'b0;
	localparam logic CFG_START_VERTEX = 1'b1;

	// Vertex identifiers are five bits wide, so the vertex limit is fixed.
	localparam int unsigned MAX_VERTICES = 32;
	localparam int unsigned VID_BITS = 5;
	localparam int unsigned VCNT_BITS = 6;

	// Status of a back-end run, reported to the front end.
	typedef struct packed {
		logic busy;
	} run_status_t;

endpackage

[hw/rtl/pmst_front.sv]
// ----------------------------------------------------------------------------
// Edge loader
// Accepts edges, writes them into the edge store and starts a run on the
// last edge of a graph.
// ----------------------------------------------------------------------------
module pmst_front #(
	parameter int unsigned MAX_EDGES = 256,
	parameter int unsigned EIDX_BITS = 8,
	parameter int unsigned WEIGHT_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [pmst_pkg::VID_BITS-1:0]      end_a,
	input  logic [pmst_pkg::VID_BITS-1:0]      end_b,
	input  logic signed [WEIGHT_BITS-1:0]      edge_weight,
	input  logic                               last_edge,
	input  pmst_pkg::run_status_t              run_status,
	output logic                               wr_en,
	output logic [EIDX_BITS-1:0]               wr_addr,
	output logic [2*pmst_pkg::VID_BITS+WEIGHT_BITS-1:0] wr_data,
	output logic                               start,
	output logic [EIDX_BITS:0]                 edge_total
);
	logic [EIDX_BITS:0] total_q;
	logic               room;
	logic               take;

	// Loading stalls from the last edge until the back end has queued the
	// final result of that graph.
	assign full = run_status.busy || start;
	assign take = push && !full;
	assign room = total_q < (EIDX_BITS+1)'(MAX_EDGES);

	assign wr_en   = take && room;
	assign wr_addr = total_q[EIDX_BITS-1:0];
	assign wr_data = {end_a, end_b, edge_weight};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			start <= 1'b0;
			edge_total <= '0;
		end else begin
			start <= 1'b0;
			if (take) begin
				if (last_edge) begin
					start <= 1'b1;
					edge_total <= total_q + (room ? 1'b1 : 1'b0);
					total_q <= '0;
				end else if (room) begin
					total_q <= total_q + 1'b1;
				end
			end
		end
	end
endmodule

[hw/rtl/pmst_back.sv]
// ----------------------------------------------------------------------------
// Prim sequencer
// Holds the edge store, scans it once per tree step, and delivers results
// through a two-entry output queue.
// ----------------------------------------------------------------------------
module pmst_back #(
	parameter int unsigned MAX_EDGES = 256,
	parameter int unsigned EIDX_BITS = 8,
	parameter int unsigned WEIGHT_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [EIDX_BITS-1:0]               wr_addr,
	input  logic [2*pmst_pkg::VID_BITS+WEIGHT_BITS-1:0] wr_data,
	input  logic                               start,
	input  logic [EIDX_BITS:0]                 edge_total,
	input  logic [pmst_pkg::VCNT_BITS-1:0]     vertex_count,
	input  logic [pmst_pkg::VID_BITS-1:0]      start_vertex,
	output pmst_pkg::run_status_t              run_status,
	output logic                               empty,
	input  logic                               pop,
	output logic [pmst_pkg::VID_BITS-1:0]      tree_end_a,
	output logic [pmst_pkg::VID_BITS-1:0]      tree_end_b,
	output logic signed [WEIGHT_BITS-1:0]      tree_weight,
	output logic [1:0]                         result_status,
	output logic                               last_result
);
	localparam int unsigned VB = pmst_pkg::VID_BITS;
	localparam int unsigned NV = pmst_pkg::MAX_VERTICES;
	localparam int unsigned VCNT_BITS_L = pmst_pkg::VCNT_BITS;
	localparam int unsigned DW = 2*VB + WEIGHT_BITS;
	localparam int unsigned LIST_DEPTH = NV - 1;
	localparam int unsigned LB = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int unsigned RW = DW + 3;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_TAIL, ST_EMIT_L, ST_EMIT_M, ST_EMIT, ST_WAIT
	} state_t;

	logic [DW-1:0] mem [MAX_EDGES];
	logic [EIDX_BITS-1:0] list_mem [LIST_DEPTH];

	state_t state_q;
	logic [EIDX_BITS:0] total_q, idx_q;
	logic [VCNT_BITS_L-1:0] count_q;
	logic [NV-1:0] tree_q;
	logic [LB:0] size_q, emit_q;
	logic found_q;
	logic [EIDX_BITS-1:0] best_q;
	logic [VB-1:0] best_a_q, best_b_q;
	logic signed [WEIGHT_BITS-1:0] best_w_q;
	logic [DW-1:0] rd_s1;
	logic rd_vld_s1;
	logic [EIDX_BITS-1:0] rd_idx_s1;
	logic [EIDX_BITS-1:0] list_rd_q;
	logic [EIDX_BITS-1:0] rd_addr;

	// Two-entry result queue.
	logic [RW-1:0] q_data_q [2];
	logic [1:0] q_cnt_q;
	logic q_rd_q;
	logic enq;
	logic [RW-1:0] enq_data;
	logic deq;

	logic [VB-1:0] ra, rb;
	logic signed [WEIGHT_BITS-1:0] rw;
	logic in_a, in_b, ok;
	assign {ra, rb, rw} = rd_s1;
	assign in_a = tree_q[ra];
	assign in_b = tree_q[rb];
	assign ok = rd_vld_s1 && ({1'b0, ra} < count_q) && ({1'b0, rb} < count_q) && (in_a != in_b);

	// While emitting, the edge store is addressed by the selection list entry.
	assign rd_addr = (state_q == ST_EMIT_M || state_q == ST_EMIT) ? list_rd_q :
		idx_q[EIDX_BITS-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_s1 <= mem[rd_addr];
		list_rd_q <= list_mem[emit_q[LB-1:0]];
		if (state_q == ST_TAIL && found_q)
			list_mem[size_q[LB-1:0]] <= best_q;
		if (enq) q_data_q[q_rd_q ^ q_cnt_q[0]] <= enq_data;
	end

	assign deq = pop && !empty;
	assign empty = (q_cnt_q == 2'd0);
	assign {tree_end_a, tree_end_b, tree_weight, result_status, last_result} =
		q_data_q[q_rd_q];

	logic space;
	assign space = (q_cnt_q != 2'd2) || deq;

	always_comb begin
		enq = 1'b0;
		enq_data = {rd_s1, pmst_pkg::STATUS_EDGE,
			(emit_q + 1'b1 == size_q)};
		unique case (state_q)
			ST_TAIL: begin
				if (!found_q) begin
					enq = space;
					enq_data = {{DW{1'b0}}, pmst_pkg::STATUS_DISCONNECTED, 1'b1};
				end
			end
			ST_EMIT: begin
				enq = space;
			end
			ST_WAIT: begin
				enq = space;
				enq_data = {{DW{1'b0}}, pmst_pkg::STATUS_SINGLE, 1'b1};
			end
			default: ;
		endcase
	end

	logic [VCNT_BITS_L-1:0] cnt_sat;
	logic [VB-1:0] st_v;
	always_comb begin
		cnt_sat = vertex_count;
		if (cnt_sat == '0) cnt_sat = VCNT_BITS_L'(1);
		if (cnt_sat > VCNT_BITS_L'(NV)) cnt_sat = VCNT_BITS_L'(NV);
		st_v = ({1'b0, start_vertex} >= cnt_sat) ? '0 : start_vertex;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			q_cnt_q <= '0;
			q_rd_q <= 1'b0;
			total_q <= '0;
			idx_q <= '0;
			count_q <= '0;
			tree_q <= '0;
			size_q <= '0;
			emit_q <= '0;
			found_q <= 1'b0;
			best_q <= '0;
			best_a_q <= '0;
			best_b_q <= '0;
			best_w_q <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			run_status <= '0;
		end else begin
			if (deq) q_rd_q <= !q_rd_q;
			q_cnt_q <= q_cnt_q + (enq ? 2'd1 : 2'd0) - (deq ? 2'd1 : 2'd0);
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= idx_q[EIDX_BITS-1:0];
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						run_status.busy <= 1'b1;
						count_q <= cnt_sat;
						total_q <= edge_total;
						tree_q <= NV'(1) << st_v;
						size_q <= '0;
						idx_q <= '0;
						found_q <= 1'b0;
						state_q <= (cnt_sat == VCNT_BITS_L'(1)) ? ST_WAIT : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (ok && (!found_q || rw < best_w_q)) begin
						found_q <= 1'b1;
						best_q <= rd_idx_s1;
						best_a_q <= ra;
						best_b_q <= rb;
						best_w_q <= rw;
					end
					if (idx_q < total_q) begin
						rd_vld_s1 <= 1'b1;
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					// The last read of the scan was folded in on the previous edge.
					if (!found_q) begin
						if (space) begin
							state_q <= ST_IDLE;
							run_status.busy <= 1'b0;
						end
					end else begin
						tree_q <= tree_q | (NV'(1) << best_a_q) | (NV'(1) << best_b_q);
						size_q <= size_q + 1'b1;
						idx_q <= '0;
						found_q <= 1'b0;
						if (VCNT_BITS_L'(size_q) + VCNT_BITS_L'(2) >= count_q) begin
							emit_q <= '0;
							state_q <= ST_EMIT_L;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_EMIT_L: begin
					// list_rd_q picks up the entry for emit_q on this edge.
					state_q <= ST_EMIT_M;
				end
				ST_EMIT_M: begin
					// rd_s1 picks up the selected edge on this edge.
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (space) begin
						if (emit_q + 1'b1 == size_q) begin
							state_q <= ST_IDLE;
							run_status.busy <= 1'b0;
						end else begin
							emit_q <= emit_q + 1'b1;
							state_q <= ST_EMIT_L;
						end
					end
				end
				ST_WAIT: begin
					if (space) begin
						state_q <= ST_IDLE;
						run_status.busy <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[hw/rtl/prim_minimum_spanning_tree_core.sv]
// ----------------------------------------------------------------------------
// Prim minimum spanning tree core
// Loads an edge list and emits the minimum spanning tree in selection order.
// ----------------------------------------------------------------------------
// Edges are taken one per cycle while full is low. The last edge starts a
// run and raises full through the registered start strobe: for each of up
// to vertex_count-1 tree steps the sequencer streams the loaded edges
// through one compare unit, one edge per cycle, and each tree edge is then
// looked up in the selection list, read back from the edge store and queued.
// Full drops once the final result of the graph sits in the two-entry result
// queue, so the next graph can load while the last results drain. Write the
// configuration registers only while no graph is being solved.
module prim_minimum_spanning_tree_core #(
	parameter int unsigned MAX_EDGES = 256,
	parameter int unsigned WEIGHT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [4:0]                    end_a,
	input  logic [4:0]                    end_b,
	input  logic signed [WEIGHT_BITS-1:0] edge_weight,
	input  logic                          last_edge,
	output logic                          empty,
	input  logic                          pop,
	output logic [4:0]                    tree_end_a,
	output logic [4:0]                    tree_end_b,
	output logic signed [WEIGHT_BITS-1:0] tree_weight,
	output logic [1:0]                    result_status,
	output logic                          last_result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [5:0]                    cfg_data
);
	localparam int unsigned EIDX_BITS = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int unsigned DW = 10 + WEIGHT_BITS;

	logic [5:0] vertex_count_q;
	logic [4:0] start_vertex_q;
	pmst_pkg::run_status_t run_status;
	logic wr_en, start;
	logic [EIDX_BITS-1:0] wr_addr;
	logic [DW-1:0] wr_data;
	logic [EIDX_BITS:0] edge_total;

	// Configuration transfers are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= 6'd1;
			start_vertex_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == pmst_pkg::CFG_VERTEX_COUNT) vertex_count_q <= cfg_data;
			else start_vertex_q <= cfg_data[4:0];
		end
	end

	pmst_front #(.MAX_EDGES(MAX_EDGES), .EIDX_BITS(EIDX_BITS),
		.WEIGHT_BITS(WEIGHT_BITS)) u_front (
		.clk, .arst_n, .push, .full, .end_a, .end_b, .edge_weight, .last_edge,
		.run_status, .wr_en, .wr_addr, .wr_data, .start, .edge_total
	);

	pmst_back #(.MAX_EDGES(MAX_EDGES),
		.EIDX_BITS(EIDX_BITS), .WEIGHT_BITS(WEIGHT_BITS)) u_back (
		.clk, .arst_n, .wr_en, .wr_addr, .wr_data, .start, .edge_total,
		.vertex_count(vertex_count_q), .start_vertex(start_vertex_q),
		.run_status, .empty, .pop, .tree_end_a, .tree_end_b, .tree_weight,
		.result_status, .last_result
	);

	// A status result is always the final result of its graph.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result_status != pmst_pkg::STATUS_EDGE) |-> last_result)
		else $error("status result without last flag");

	// A run start is followed by a busy loader.
	assert property (@(posedge clk) disable iff (!arst_n)
		start |=> full)
		else $error("loader not stalled during run");
endmodule
